// File: rtl/core/yar_pkg.sv
// yar_pkg: shared types and constants for the YUV to ARGB rotate block.
// No dependencies.
package yar_pkg;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned SMP_W  = 8;
  localparam int unsigned REG_W  = 13;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [1:0] {
    REG_ROTATION = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_HEIGHT   = 2'd2,
    REG_STRIDE   = 2'd3
  } cfg_reg_e;

  // address = mul_a * stride + add_b, modulo 2^24
  typedef struct packed {
    logic [ADDR_W-1:0] mul_a;
    logic [ADDR_W-1:0] add_b;
    logic              last;
  } addr_op_t;

endpackage

// File: rtl/core/yar_scan.sv
// yar_scan: column/row counters and rotated address operands.
// Depends on yar_pkg.
module yar_scan #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  yar_pkg::rot_e               rotation_i,
  input  logic [yar_pkg::REG_W-1:0]   frame_width_i,
  input  logic [yar_pkg::REG_W-1:0]   frame_height_i,
  output yar_pkg::addr_op_t           op_o
);

  localparam int unsigned EW = (DIM_BITS + 1 > yar_pkg::REG_W) ? DIM_BITS + 1 : yar_pkg::REG_W;
  localparam logic [EW-1:0] DimMax = EW'(1) << DIM_BITS;

  logic [DIM_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [EW-1:0]       w_ext, h_ext, w_eff, h_eff;
  logic                col_last, row_last;
  logic [yar_pkg::ADDR_W-1:0] rc, cc, r24, c24;

  always_comb begin
    w_ext = EW'(frame_width_i);
    h_ext = EW'(frame_height_i);
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > DimMax) begin
      w_eff = DimMax;
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = EW'(1);
    end else if (h_ext > DimMax) begin
      h_eff = DimMax;
    end else begin
      h_eff = h_ext;
    end
    col_last = EW'(col_q) >= (w_eff - EW'(1));
    row_last = EW'(row_q) >= (h_eff - EW'(1));
    r24 = yar_pkg::ADDR_W'(row_q);
    c24 = yar_pkg::ADDR_W'(col_q);
    rc  = yar_pkg::ADDR_W'(h_eff) - yar_pkg::ADDR_W'(1) - r24;
    cc  = yar_pkg::ADDR_W'(w_eff) - yar_pkg::ADDR_W'(1) - c24;
  end

  always_comb begin
    op_o.last = col_last && row_last;
    unique case (rotation_i)
      yar_pkg::ROT_0: begin
        op_o.mul_a = r24;
        op_o.add_b = c24;
      end
      yar_pkg::ROT_90: begin
        op_o.mul_a = c24;
        op_o.add_b = rc;
      end
      yar_pkg::ROT_180: begin
        op_o.mul_a = rc;
        op_o.add_b = cc;
      end
      default: begin
        op_o.mul_a = cc;
        op_o.add_b = r24;
      end
    endcase
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (adv_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + DIM_BITS'(1);
      end else begin
        col_d = col_q + DIM_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && op_o.last) |=> (col_q == '0 && row_q == '0))
    else $error("counters did not wrap after last pixel");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && !col_last) |=> (col_q == DIM_BITS'($past(col_q) + DIM_BITS'(1))
                              && row_q == $past(row_q)))
    else $error("column did not step");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> (col_q == $past(col_q) && row_q == $past(row_q)))
    else $error("counters moved without an item");

endmodule

// File: rtl/core/yar_csc.sv
// yar_csc: BT.601 video-range YUV to ARGB8888 fixed-point conversion.
// Depends on yar_pkg.
module yar_csc #(
  parameter int unsigned CLAMP_MAX = 262143
) (
  input  logic [yar_pkg::SMP_W-1:0] luma_i,
  input  logic [yar_pkg::SMP_W-1:0] cb_i,
  input  logic [yar_pkg::SMP_W-1:0] cr_i,
  output logic [yar_pkg::PIX_W-1:0] argb_o
);

  localparam int unsigned SW = 23;
  localparam logic signed [SW-1:0] CMax = SW'(CLAMP_MAX);

  logic [yar_pkg::SMP_W-1:0] y_off;
  logic signed [SW-1:0]      ys, us, vs, r_sum, g_sum, b_sum;

  function automatic logic [7:0] clamp_ch(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    if (v < 0) begin
      t = '0;
    end else if (v > CMax) begin
      t = CMax;
    end else begin
      t = v;
    end
    return t[17:10];
  endfunction

  always_comb begin
    y_off = (luma_i >= 8'd16) ? luma_i - 8'd16 : '0;
    ys    = $signed({15'd0, y_off});
    us    = $signed({15'd0, cb_i}) - 23'sd128;
    vs    = $signed({15'd0, cr_i}) - 23'sd128;
    r_sum = 23'sd1192 * ys + 23'sd1634 * vs;
    g_sum = 23'sd1192 * ys - 23'sd833 * vs - 23'sd400 * us;
    b_sum = 23'sd1192 * ys + 23'sd2066 * us;
    argb_o = {8'hff, clamp_ch(r_sum), clamp_ch(g_sum), clamp_ch(b_sum)};
  end

endmodule

// File: rtl/core/yuv_to_argb_rotate_top.sv
// yuv_to_argb_rotate_top: YUV pixel stream (luma, cb, cr per item) to ARGB8888 with rotated addresses.
// Depends on yar_pkg, yar_scan, yar_csc.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: luma, cb, cr
//  m_axis   | out | m_axis_tvalid/tready   | tdata: out_address, pixel_argb; tlast: frame_last
//  cfg      | in  | cfg_we_i (no stall)    | cfg_idx_i, cfg_data_i
//
// One item per cycle unless m_axis stalls; path: input register, then result register.
// The stride multiply and color conversion sit between the two registers.
// Reset clears counters, valid flags and config to defaults.
// A stalled output holds the result register and a full input register; s_axis_tready drops only when both are full.
module yuv_to_argb_rotate_top #(
  parameter int unsigned CLAMP_MAX = 262143,
  parameter int unsigned DIM_BITS  = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,   // [7:0] luma, [15:8] cb, [23:16] cr
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [55:0]               m_axis_tdata,   // [23:0] out_address, [55:24] pixel_argb
  output logic                      m_axis_tlast,   // frame_last
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [yar_pkg::REG_W-1:0] cfg_data_i
);

  yar_pkg::rot_e              rotation_q;
  logic [yar_pkg::REG_W-1:0]  width_q, height_q, stride_q;

  logic                       s1_valid_q, out_valid_q;
  logic [23:0]                s1_pix_q;
  yar_pkg::addr_op_t          s1_op_q, op;
  logic [yar_pkg::ADDR_W-1:0] prod, addr_d, out_addr_q;
  logic [yar_pkg::PIX_W-1:0]  argb_d, out_argb_q;
  logic                       out_last_q;
  logic                       adv_out, adv_in;

  assign adv_out       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv_out;
  assign adv_in        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= yar_pkg::ROT_0;
      width_q    <= 13'd640;
      height_q   <= 13'd480;
      stride_q   <= 13'd640;
    end else if (cfg_we_i) begin
      unique case (yar_pkg::cfg_reg_e'(cfg_idx_i))
        yar_pkg::REG_ROTATION: rotation_q <= yar_pkg::rot_e'(cfg_data_i[1:0]);
        yar_pkg::REG_WIDTH:    width_q    <= cfg_data_i;
        yar_pkg::REG_HEIGHT:   height_q   <= cfg_data_i;
        default:               stride_q   <= cfg_data_i;
      endcase
    end
  end

  yar_scan #(
    .DIM_BITS(DIM_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv_in),
    .rotation_i    (rotation_q),
    .frame_width_i (width_q),
    .frame_height_i(height_q),
    .op_o          (op)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      s1_pix_q <= s_axis_tdata;
      s1_op_q  <= op;
    end
  end

  yar_csc #(
    .CLAMP_MAX(CLAMP_MAX)
  ) u_csc (
    .luma_i(s1_pix_q[7:0]),
    .cb_i  (s1_pix_q[15:8]),
    .cr_i  (s1_pix_q[23:16]),
    .argb_o(argb_d)
  );

  assign prod   = s1_op_q.mul_a * {11'd0, stride_q};
  assign addr_d = prod + s1_op_q.add_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s1_valid_q) begin
      out_addr_q <= addr_d;
      out_argb_q <= argb_d;
      out_last_q <= s1_op_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_argb_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv_out) |=> (s1_valid_q && $stable(s1_pix_q) && $stable(s1_op_q)))
    else $error("stage one lost its item under stall");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a staged item");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_argb_q[31:24] == 8'hff))
    else $error("alpha byte not opaque");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken with both stages full");

endmodule
